// ===== sv/ellipse_span_rasterizer_core_defines.svh =====
// Assertion macros for the ellipse span rasterizer checker.
`ifndef ELLIPSE_SPAN_RASTERIZER_CORE_DEFINES_SVH
`define ELLIPSE_SPAN_RASTERIZER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ESR_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ESR_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/esr_pkg.sv =====
// Shared types, constants and the microcode program of the ellipse span rasterizer.
package esr_pkg;

  // Width of the box side fields on the input channel.
  localparam int SIDE_IN_W   = 7;
  // Most results one rectangle may produce.
  localparam int MAX_RESULTS = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_HINIT,
    ST_EINIT,
    ST_WALK,
    ST_FLUSH
  } step_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SQ_A,
    OP_SQ_B,
    OP_HINIT,
    OP_EINIT,
    OP_WALK,
    OP_FLUSH
  } op_t;

  // Operand pair for the shared multiplier.
  typedef enum logic [1:0] {
    MS_RA,
    MS_RB,
    MS_HALF
  } mul_sel_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_START,
    JC_WALK,
    JC_FLUSH
  } jc_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t mul;
    jc_t      jc;
    step_t    target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic walk_go;
    logic hold;
    logic half;
  } seq_stat_t;

  function automatic ctrl_t ucode_rom(step_t s);
    ctrl_t w;
    w = '{op: OP_LOAD, mul: MS_RA, jc: JC_START, target: ST_SQ_A};
    unique case (s)
      ST_IDLE:  w = '{op: OP_LOAD,  mul: MS_RA,   jc: JC_START, target: ST_SQ_A};
      ST_SQ_A:  w = '{op: OP_SQ_A,  mul: MS_RA,   jc: JC_NEXT,  target: ST_SQ_B};
      ST_SQ_B:  w = '{op: OP_SQ_B,  mul: MS_RB,   jc: JC_NEXT,  target: ST_HINIT};
      ST_HINIT: w = '{op: OP_HINIT, mul: MS_HALF, jc: JC_NEXT,  target: ST_EINIT};
      ST_EINIT: w = '{op: OP_EINIT, mul: MS_HALF, jc: JC_NEXT,  target: ST_WALK};
      // The walk loops on itself; on exit it restarts the second half or falls through.
      ST_WALK:  w = '{op: OP_WALK,  mul: MS_HALF, jc: JC_WALK,  target: ST_HINIT};
      ST_FLUSH: w = '{op: OP_FLUSH, mul: MS_HALF, jc: JC_FLUSH, target: ST_IDLE};
      default:  w = '{op: OP_LOAD,  mul: MS_RA,   jc: JC_START, target: ST_SQ_A};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/esr_in_if.sv =====
// Input channel carrying one bounding rectangle per beat.
interface esr_in_if #(parameter int COORD_BITS = 16);
  logic                                  valid;
  logic                                  ready;
  logic signed [COORD_BITS-1:0]          origin_x;
  logic signed [COORD_BITS-1:0]          origin_y;
  logic        [esr_pkg::SIDE_IN_W-1:0]  box_width;
  logic        [esr_pkg::SIDE_IN_W-1:0]  box_height;

  modport source (output valid, origin_x, origin_y, box_width, box_height, input ready);
  modport sink   (input valid, origin_x, origin_y, box_width, box_height, output ready);
endinterface

// ===== sv/esr_out_if.sv =====
// Result channel carrying one mirrored ellipse step per beat.
interface esr_out_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] left_x;
  logic signed [COORD_BITS-1:0] right_x;
  logic signed [COORD_BITS-1:0] upper_y;
  logic signed [COORD_BITS-1:0] lower_y;
  logic                         last;

  modport source (output valid, left_x, right_x, upper_y, lower_y, last, input ready);
  modport sink   (input valid, left_x, right_x, upper_y, lower_y, last, output ready);
endinterface

// ===== sv/ellipse_span_rasterizer_core.sv =====
// A nonempty rectangle holds the input until all its results (at most 48) have entered the output register.
// An empty rectangle is taken and dropped, and the input stays ready.
// The squaring and init steps run before the walk, and each result waits in a one-deep stage
// until the next one shows whether it is last.
// The walk loop advances one result per cycle; output stalls hold it in place.
// Reset (synchronous, active low) returns the sequencer to idle and clears all valid flags.
module ellipse_span_rasterizer_core #(
  parameter int MAX_SIDE   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  esr_in_if.sink    in_ch,
  esr_out_if.source out_ch
);
  import esr_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int AX_W   = SIDE_W - 1;
  localparam int SQ_W   = 2 * AX_W;
  localparam int MUL_W  = SQ_W + AX_W;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int OFF_W  = ((AX_W > CNT_W) ? AX_W : CNT_W) + 1;
  localparam int PROD_W = SQ_W + OFF_W + 1;
  localparam int ERR_W  = ((2 * SQ_W > PROD_W) ? 2 * SQ_W : PROD_W) + 4;

  ctrl_t     ctrl;
  seq_stat_t stat;

  esr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Rectangle geometry.
  logic        [AX_W-1:0]       ra_r, rb_r;
  logic        [SQ_W-1:0]       aa_r, bb_r;
  logic signed [COORD_BITS-1:0] xl_r, xr_r, yt_r, yb_r;

  // Walk state; u steps up, v steps down, roles of the axes swap per half.
  logic                         half_r;
  logic        [CNT_W-1:0]      cnt_r;
  logic signed [OFF_W-1:0]      u_r, v_r;
  logic signed [PROD_W-1:0]     bu_r, av_r;
  logic signed [ERR_W-1:0]      err_r;

  // One-deep lookahead stage and output register.
  logic                         pend_v_r;
  logic signed [COORD_BITS-1:0] pend_left_r, pend_right_r, pend_upper_r, pend_lower_r;
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_left_r, out_right_r, out_upper_r, out_lower_r;
  logic                         out_last_r;

  // Input side decode.
  logic        [SIDE_IN_W-1:0]  w_in, h_in;
  logic        [SIDE_W-1:0]     w_sat, h_sat, wm1, hm1;
  logic        [AX_W-1:0]       ra_in, rb_in;
  logic                         box_empty;

  always_comb begin
    w_in      = in_ch.box_width;
    h_in      = in_ch.box_height;
    box_empty = (w_in == '0) || (h_in == '0);
    w_sat     = (w_in > SIDE_IN_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : w_in[SIDE_W-1:0];
    h_sat     = (h_in > SIDE_IN_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : h_in[SIDE_W-1:0];
    wm1       = w_sat - SIDE_W'(1);
    hm1       = h_sat - SIDE_W'(1);
    ra_in     = wm1[SIDE_W-1:1];
    rb_in     = hm1[SIDE_W-1:1];
  end

  // Per-half operand roles.
  logic        [SQ_W-1:0]       a_sel, b_sel;
  logic        [AX_W-1:0]       v0_sel;
  logic        [SQ_W-1:0]       mul_x;
  logic        [AX_W-1:0]       mul_y;
  logic        [MUL_W-1:0]      prod;

  always_comb begin
    a_sel  = half_r ? bb_r : aa_r;
    b_sel  = half_r ? aa_r : bb_r;
    v0_sel = half_r ? ra_r : rb_r;
    case (ctrl.mul)
      MS_RA: begin
        mul_x = {{(SQ_W-AX_W){1'b0}}, ra_r};
        mul_y = ra_r;
      end
      MS_RB: begin
        mul_x = {{(SQ_W-AX_W){1'b0}}, rb_r};
        mul_y = rb_r;
      end
      default: begin
        mul_x = a_sel;
        mul_y = v0_sel;
      end
    endcase
    prod = mul_x * mul_y;
  end

  // Decision variable arithmetic.
  logic signed [ERR_W-1:0]      a_e, b_e, av_e, bu_e, err_corr, err_walk, err_init;
  logic signed [PROD_W-1:0]     a_p, b_p;
  logic                         err_neg;

  always_comb begin
    a_e      = signed'({{(ERR_W-SQ_W){1'b0}}, a_sel});
    b_e      = signed'({{(ERR_W-SQ_W){1'b0}}, b_sel});
    a_p      = signed'({{(PROD_W-SQ_W){1'b0}}, a_sel});
    b_p      = signed'({{(PROD_W-SQ_W){1'b0}}, b_sel});
    av_e     = {{(ERR_W-PROD_W){av_r[PROD_W-1]}}, av_r};
    bu_e     = {{(ERR_W-PROD_W){bu_r[PROD_W-1]}}, bu_r};
    err_neg  = err_r[ERR_W-1];
    // A non-negative error also steps v down, which costs 4A(1 - v).
    err_corr = err_neg ? '0 : ((a_e <<< 2) - (av_e <<< 2));
    err_walk = err_r + err_corr + (bu_e <<< 2) + (b_e <<< 2) + (b_e <<< 1);
    err_init = (b_e <<< 1) + a_e - (av_e <<< 1);
  end

  // Step control.
  logic is_walk, is_flush, out_free, walk_go, hold, walk_adv, flush_push, out_push;

  always_comb begin
    is_walk    = (ctrl.op == OP_WALK);
    is_flush   = (ctrl.op == OP_FLUSH);
    out_free   = !out_valid_r || out_ch.ready;
    walk_go    = !v_r[OFF_W-1] && (bu_r <= av_r) && (cnt_r < CNT_W'(MAX_RESULTS));
    hold       = pend_v_r && !out_free && ((is_walk && walk_go) || is_flush);
    walk_adv   = is_walk && walk_go && !hold;
    flush_push = is_flush && pend_v_r && out_free;
    out_push   = (walk_adv && pend_v_r) || flush_push;
    stat.start   = in_ch.valid && !box_empty;
    stat.walk_go = walk_go;
    stat.hold    = hold;
    stat.half    = half_r;
  end

  // Mirrored coordinates of the current step.
  logic signed [OFF_W-1:0]      dx_sel, dy_sel;
  logic signed [COORD_BITS-1:0] dx_c, dy_c;

  always_comb begin
    dx_sel = half_r ? v_r : u_r;
    dy_sel = half_r ? u_r : v_r;
    dx_c   = {{(COORD_BITS-OFF_W){dx_sel[OFF_W-1]}}, dx_sel};
    dy_c   = {{(COORD_BITS-OFF_W){dy_sel[OFF_W-1]}}, dy_sel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= 1'b0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.op == OP_LOAD) begin
        half_r <= 1'b0;
        cnt_r  <= '0;
      end
      if (is_walk && !walk_go) begin
        half_r <= 1'b1;
      end
      if (walk_adv) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (walk_adv) begin
        pend_v_r <= 1'b1;
      end else if (flush_push) begin
        pend_v_r <= 1'b0;
      end
      if (out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        ra_r <= ra_in;
        rb_r <= rb_in;
        xl_r <= in_ch.origin_x + {{(COORD_BITS-AX_W){1'b0}}, ra_in};
        xr_r <= in_ch.origin_x + {{(COORD_BITS-AX_W){1'b0}}, w_sat[SIDE_W-1:1]};
        yb_r <= in_ch.origin_y + {{(COORD_BITS-AX_W){1'b0}}, rb_in};
        yt_r <= in_ch.origin_y + {{(COORD_BITS-AX_W){1'b0}}, h_sat[SIDE_W-1:1]};
      end
      OP_SQ_A: aa_r <= prod[SQ_W-1:0];
      OP_SQ_B: bb_r <= prod[SQ_W-1:0];
      OP_HINIT: begin
        u_r  <= '0;
        v_r  <= signed'({{(OFF_W-AX_W){1'b0}}, v0_sel});
        bu_r <= '0;
        av_r <= signed'({{(PROD_W-MUL_W){1'b0}}, prod});
      end
      OP_EINIT: err_r <= err_init;
      OP_WALK: begin
        if (walk_adv) begin
          pend_left_r  <= xl_r - dx_c;
          pend_right_r <= xr_r + dx_c;
          pend_upper_r <= yt_r + dy_c;
          pend_lower_r <= yb_r - dy_c;
          u_r   <= u_r + OFF_W'(1);
          bu_r  <= bu_r + b_p;
          err_r <= err_walk;
          if (!err_neg) begin
            v_r  <= v_r - OFF_W'(1);
            av_r <= av_r - a_p;
          end
        end
      end
      default: ;
    endcase
    if (out_push) begin
      out_left_r  <= pend_left_r;
      out_right_r <= pend_right_r;
      out_upper_r <= pend_upper_r;
      out_lower_r <= pend_lower_r;
      out_last_r  <= flush_push;
    end
  end

  assign in_ch.ready    = (ctrl.op == OP_LOAD);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.left_x  = out_left_r;
  assign out_ch.right_x = out_right_r;
  assign out_ch.upper_y = out_upper_r;
  assign out_ch.lower_y = out_lower_r;
  assign out_ch.last    = out_last_r;

endmodule

// ===== sv/esr_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
module esr_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  esr_pkg::seq_stat_t  stat,
  output esr_pkg::ctrl_t      ctrl
);
  import esr_pkg::*;

  step_t pc_r;
  step_t pc_nxt;

  always_comb begin
    ctrl = ucode_rom(pc_r);
  end

  always_comb begin
    pc_nxt = pc_r;
    unique case (ctrl.jc)
      JC_NEXT:  pc_nxt = step_t'(pc_r + 3'd1);
      JC_START: pc_nxt = stat.start ? ctrl.target : pc_r;
      JC_WALK: begin
        if (stat.hold || stat.walk_go) begin
          pc_nxt = pc_r;
        end else if (!stat.half) begin
          pc_nxt = ctrl.target;
        end else begin
          pc_nxt = step_t'(pc_r + 3'd1);
        end
      end
      JC_FLUSH: pc_nxt = stat.hold ? pc_r : ctrl.target;
      default:  pc_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== sv/esr_checker.sv =====
// Port-level checker for the ellipse span rasterizer and its bind to the top level.
`include "ellipse_span_rasterizer_core_defines.svh"

module esr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [esr_pkg::SIDE_IN_W-1:0] in_box_width,
  input logic [esr_pkg::SIDE_IN_W-1:0] in_box_height,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_last
);

  logic in_beat, in_nonempty;

  assign in_beat     = in_valid && in_ready;
  assign in_nonempty = (in_box_width != '0) && (in_box_height != '0);

  `ESR_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `ESR_ASSERT_NEXT(a_busy_after_box, clk, rst_n, in_beat && in_nonempty, !in_ready, "input still ready after a nonempty rectangle")
  `ESR_ASSERT_NEXT(a_empty_box_drops, clk, rst_n, in_beat && !in_nonempty, in_ready, "empty rectangle did not leave the input ready")
  `ESR_ASSERT_SAME(a_run_open, clk, rst_n, out_valid && !out_last, !in_ready, "input ready while a run is still open")

endmodule

bind ellipse_span_rasterizer_core esr_checker u_esr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_box_width  (in_ch.box_width),
  .in_box_height (in_ch.box_height),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_last      (out_ch.last)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the ellipse span rasterizer core, with its own span predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int COORD_W        = 16;
  localparam int BOX_SIDE_MAX   = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] right_x;
    logic [COORD_W-1:0] upper_y;
    logic [COORD_W-1:0] lower_y;
    logic               last;
  } span_beat_t;

  logic clk;
  logic rst_n;

  esr_in_if  #(.COORD_BITS(COORD_W)) in_ch ();
  esr_out_if #(.COORD_BITS(COORD_W)) out_ch ();

  ellipse_span_rasterizer_core #(
    .MAX_SIDE  (BOX_SIDE_MAX),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  span_beat_t pending_spans[$];
  int         mismatch_count;
  int         boxes_taken;
  int         empty_boxes;
  int         spans_checked;
  int         sink_wait;
  int         idle_cycles;
  bit         steady_flow;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    if (steady_flow) begin
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Walks both halves of the midpoint ellipse and queues one span beat per step.
  // The last flag is set on the final beat, so each beat is held back one step.
  task automatic plan_ellipse_spans(input logic [COORD_W-1:0] ox_in,
                                    input logic [COORD_W-1:0] oy_in,
                                    input logic [6:0] bw, input logic [6:0] bh);
    int         w, h, ra, rb, aa, bb, xl, xr, yt, yb, dx, dy, err, cnt, ox, oy, phase;
    span_beat_t held;
    bit         have_held;
    ox = int'($signed(ox_in));
    oy = int'($signed(oy_in));
    w = int'(bw);
    h = int'(bh);
    have_held = 1'b0;
    held = '0;
    cnt = 0;
    if (w == 0 || h == 0) begin
      empty_boxes++;
      return;
    end
    if (w > BOX_SIDE_MAX) w = BOX_SIDE_MAX;
    if (h > BOX_SIDE_MAX) h = BOX_SIDE_MAX;
    ra = (w - 1) / 2;
    rb = (h - 1) / 2;
    aa = ra * ra;
    bb = rb * rb;
    xl = ox + (w - 1) / 2;
    xr = ox + w / 2;
    yb = oy + (h - 1) / 2;
    yt = oy + h / 2;
    for (phase = 0; phase < 2; phase++) begin
      if (phase == 0) begin
        dx = 0;
        dy = rb;
        err = 2 * bb + aa * (1 - 2 * rb);
      end else begin
        dx = ra;
        dy = 0;
        err = 2 * aa + bb * (1 - 2 * ra);
      end
      while (cnt < esr_pkg::MAX_RESULTS &&
             ((phase == 0) ? (dy >= 0 && bb * dx <= aa * dy)
                           : (dx >= 0 && aa * dy <= bb * dx))) begin
        if (have_held) pending_spans.push_back(held);
        held.left_x  = COORD_W'(xl - dx);
        held.right_x = COORD_W'(xr + dx);
        held.upper_y = COORD_W'(yt + dy);
        held.lower_y = COORD_W'(yb - dy);
        held.last    = 1'b0;
        have_held = 1'b1;
        cnt++;
        if (phase == 0) begin
          if (err >= 0) begin
            err += 4 * aa * (1 - dy);
            dy -= 1;
          end
          err += bb * (4 * dx + 6);
          dx += 1;
        end else begin
          if (err >= 0) begin
            err += 4 * bb * (1 - dx);
            dx -= 1;
          end
          err += aa * (4 * dy + 6);
          dy += 1;
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pending_spans.push_back(held);
    end
  endtask

  // Offers one rectangle and returns right after the edge that takes it.
  task automatic send_box(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                          input logic [6:0] bw, input logic [6:0] bh);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.origin_x   <= ox;
    in_ch.origin_y   <= oy;
    in_ch.box_width  <= bw;
    in_ch.box_height <= bh;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    boxes_taken++;
    plan_ellipse_spans(ox, oy, bw, bh);
  endtask

  function automatic logic [6:0] pick_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 7'd0;
    if (r < 22) return 7'($urandom_range(1, 4));
    if (r < 35) return 7'($urandom_range(65, 127));
    return 7'($urandom_range(5, 64));
  endfunction

  function automatic logic [COORD_W-1:0] pick_origin();
    // Some origins sit around the top of the signed range so the walk wraps.
    if ($urandom_range(0, 4) == 0) return 16'h7FC0 + 16'($urandom_range(0, 127));
    return 16'($urandom);
  endfunction

  task automatic test_directed_boxes();
    send_box(16'd0, 16'd0, 7'd0, 7'd5);
    send_box(16'd10, 16'd10, 7'd5, 7'd0);
    send_box(16'd3, 16'd4, 7'd0, 7'd0);
    send_box(16'd100, 16'd200, 7'd1, 7'd1);
    send_box(16'd7, 16'd9, 7'd2, 7'd2);
    send_box(16'd0, 16'd0, 7'd1, 7'd64);
    send_box(16'd0, 16'd0, 7'd64, 7'd1);
    send_box(16'd5, 16'd5, 7'd2, 7'd64);
    send_box(16'd5, 16'd5, 7'd64, 7'd2);
    send_box(16'd0, 16'd0, 7'd3, 7'd3);
    send_box(16'd20, 16'd30, 7'd4, 7'd5);
    send_box(16'd20, 16'd30, 7'd5, 7'd4);
    send_box(16'd0, 16'd0, 7'd64, 7'd64);
    send_box(16'd0, 16'd0, 7'd63, 7'd64);
    send_box(16'd1, 16'd1, 7'd127, 7'd127);
    send_box(16'd0, 16'd0, 7'd65, 7'd3);
    send_box(16'd0, 16'd0, 7'd100, 7'd20);
    send_box(16'h7FFF, 16'h7FFF, 7'd64, 7'd64);
    send_box(16'h8000, 16'h8000, 7'd64, 7'd64);
    send_box(16'hFFFF, 16'h7FF0, 7'd33, 7'd48);
    send_box(16'h8000, 16'hFFFF, 7'd1, 7'd127);
    send_box(16'h7FE0, 16'h8010, 7'd40, 7'd9);
  endtask

  task automatic test_random_boxes(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_box(pick_origin(), pick_origin(), pick_side(), pick_side());
    end
  endtask

  task automatic test_back_to_back(input int count);
    int k;
    steady_flow = 1'b1;
    for (k = 0; k < count; k++) begin
      send_box(pick_origin(), pick_origin(), pick_side(), pick_side());
    end
    steady_flow = 1'b0;
  endtask

  // Result side: random stalls per beat, and every beat checked against the oldest prediction.
  always @(posedge clk) begin
    span_beat_t want;
    int         w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait    <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      spans_checked++;
      if (pending_spans.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected span beat: expected none, got %0d %0d %0d %0d last %0b",
                 $time, out_ch.left_x, out_ch.right_x, out_ch.upper_y, out_ch.lower_y,
                 out_ch.last);
      end else begin
        want = pending_spans.pop_front();
        if (out_ch.left_x !== want.left_x) begin
          mismatch_count++;
          $display("%0t: left_x expected %0d, got %0d", $time,
                   $signed(want.left_x), out_ch.left_x);
        end
        if (out_ch.right_x !== want.right_x) begin
          mismatch_count++;
          $display("%0t: right_x expected %0d, got %0d", $time,
                   $signed(want.right_x), out_ch.right_x);
        end
        if (out_ch.upper_y !== want.upper_y) begin
          mismatch_count++;
          $display("%0t: upper_y expected %0d, got %0d", $time,
                   $signed(want.upper_y), out_ch.upper_y);
        end
        if (out_ch.lower_y !== want.lower_y) begin
          mismatch_count++;
          $display("%0t: lower_y expected %0d, got %0d", $time,
                   $signed(want.lower_y), out_ch.lower_y);
        end
        if (out_ch.last !== want.last) begin
          mismatch_count++;
          $display("%0t: last expected %0b, got %0b", $time, want.last, out_ch.last);
        end
      end
      w = draw_wait();
      sink_wait    <= w;
      out_ch.ready <= (w == 0);
    end else if (sink_wait > 0) begin
      sink_wait    <= sink_wait - 1;
      out_ch.ready <= (sink_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles with no beat moving", idle_cycles);
      $display("ellipse_span_rasterizer_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.origin_x   = '0;
    in_ch.origin_y   = '0;
    in_ch.box_width  = '0;
    in_ch.box_height = '0;
    boxes_taken      = 0;
    empty_boxes      = 0;
    steady_flow      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_boxes();
    test_random_boxes(140);
    test_back_to_back(20);

    in_ch.valid <= 1'b0;
    while (pending_spans.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d rectangles (%0d empty) through both walk halves, checking %0d span beats.",
             boxes_taken, empty_boxes, spans_checked);
    $display("Sizes covered empty, degenerate, saturated and full sides, with coordinate wrap.");
    if (mismatch_count == 0) begin
      $display("ellipse_span_rasterizer_core verification clean");
    end else begin
      $display("ellipse_span_rasterizer_core verification failed");
    end
    $finish;
  end

endmodule

// ===== ellipse_span_rasterizer_core.f =====
+incdir+sv
sv/esr_pkg.sv
sv/esr_in_if.sv
sv/esr_out_if.sv
sv/esr_seq.sv
sv/ellipse_span_rasterizer_core.sv
sv/esr_checker.sv
sim/tb_top.sv
